// ===== rtl/escd_pkg.sv =====
// Package: shared types, state codes and character constants of the escape decoder.
`default_nettype none

package escd_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_PLAIN = 3'd0,
        ST_ESC   = 3'd1,
        ST_DEC0  = 3'd2,
        ST_DEC1  = 3'd3,
        ST_DEC2  = 3'd4,
        ST_OCT1  = 3'd5,
        ST_OCT2  = 3'd6,
        ST_HEX   = 3'd7
    } t_scan_state;

    localparam int unsigned QUEUE_DEPTH = 3;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_D         = 8'h64;
    localparam logic [7:0] CH_E         = 8'h65;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_V         = 8'h76;
    localparam logic [7:0] CH_X         = 8'h78;

    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_ESC = 8'h1B;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_HT  = 8'h09;
    localparam logic [7:0] CODE_VT  = 8'h0B;

    // Value of a hex digit; only meaningful where the byte is one.
    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [7:0] diff;
        begin
            diff = 8'h00;
            if (c inside {[8'h30:8'h39]}) begin
                diff = c - CH_ZERO;
            end else if (c inside {[8'h61:8'h66]}) begin
                diff = c - CH_LOWER_A + 8'd10;
            end else begin
                diff = c - CH_UPPER_A + 8'd10;
            end
            return diff[3:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/escape_sequence_decoder_unit.sv =====
// Top level: backslash escape decoder with a three-entry result queue.
// Results are registered into the queue; o_valid offers the oldest one first.
// Throughput: one item per cycle while the output drains one result per cycle;
// an item that gives two results fills the queue further and can hold off the next item.
// o_ready is high while at most one result waits in the queue.
// Reset (synchronous, active low) returns the scanner to plain text and empties the queue.
`default_nettype none

module escape_sequence_decoder_unit (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire escd_pkg::t_in_item i_item,
    output logic                  o_valid,
    input  wire                   i_ready,
    output escd_pkg::t_out_item   o_result
);
    import escd_pkg::*;

    t_scan_state r_state, n_state;
    logic [7:0]  r_value, n_value;
    logic        r_term, n_term;
    logic [1:0]  r_cnt, n_cnt;
    t_out_item   r_q [QUEUE_DEPTH];
    t_out_item   n_q [QUEUE_DEPTH];

    logic        in_acc;
    logic        pop;
    logic [1:0]  cnt_pop;
    logic [1:0]  push_cnt;
    logic [7:0]  res [2];
    t_out_item   sh  [QUEUE_DEPTH];
    t_out_item   res_item [2];

    assign in_acc   = i_valid && o_ready;
    assign pop      = o_valid && i_ready;
    assign o_ready  = (r_cnt <= 2'd1);
    assign o_valid  = (r_cnt != 2'd0);
    assign o_result = r_q[0];

    // Decode one byte: up to two results.
    always_comb begin
        logic [7:0] c;
        logic [7:0] d;
        logic       again;
        c        = i_item.in_byte;
        d        = c - CH_ZERO;
        again    = 1'b0;
        n_state  = r_state;
        n_value  = r_value;
        n_term   = r_term;
        push_cnt = 2'd0;
        res[0]   = 8'h00;
        res[1]   = 8'h00;

        if (in_acc) begin
            if (r_term) begin
                if (i_item.string_end) begin
                    n_state = ST_PLAIN;
                    n_value = 8'h00;
                    n_term  = 1'b0;
                end
            end else if (c == CH_NUL) begin
                if (r_state >= ST_DEC0) begin
                    res[push_cnt[0]] = r_value;
                    push_cnt         = push_cnt + 2'd1;
                end
                n_state = ST_PLAIN;
                n_value = 8'h00;
                n_term  = !i_item.string_end;
            end else begin
                case (r_state)
                    ST_PLAIN: begin
                        again = 1'b0;
                    end
                    ST_ESC: begin
                        n_state = ST_PLAIN;
                        case (c)
                            CH_B: begin res[push_cnt[0]] = CODE_BS;  push_cnt = push_cnt + 2'd1; end
                            CH_E: begin res[push_cnt[0]] = CODE_ESC; push_cnt = push_cnt + 2'd1; end
                            CH_F: begin res[push_cnt[0]] = CODE_FF;  push_cnt = push_cnt + 2'd1; end
                            CH_N: begin res[push_cnt[0]] = CODE_LF;  push_cnt = push_cnt + 2'd1; end
                            CH_R: begin res[push_cnt[0]] = CODE_CR;  push_cnt = push_cnt + 2'd1; end
                            CH_T: begin res[push_cnt[0]] = CODE_HT;  push_cnt = push_cnt + 2'd1; end
                            CH_V: begin res[push_cnt[0]] = CODE_VT;  push_cnt = push_cnt + 2'd1; end
                            CH_D: begin n_value = 8'h00; n_state = ST_DEC0; end
                            CH_X: begin n_value = 8'h00; n_state = ST_HEX;  end
                            default: begin
                                if (c inside {[8'h30:8'h37]}) begin
                                    n_value = d;
                                    n_state = ST_OCT1;
                                end else begin
                                    res[push_cnt[0]] = c;
                                    push_cnt         = push_cnt + 2'd1;
                                end
                            end
                        endcase
                    end
                    ST_DEC0, ST_DEC1, ST_DEC2: begin
                        if (c inside {[8'h30:8'h39]}) begin
                            n_value = {r_value[4:0], 3'b000} + {r_value[6:0], 1'b0} + d;
                            if (r_state == ST_DEC2) begin
                                res[push_cnt[0]] = n_value;
                                push_cnt         = push_cnt + 2'd1;
                                n_value          = 8'h00;
                                n_state          = ST_PLAIN;
                            end else begin
                                n_state = t_scan_state'(r_state + 3'd1);
                            end
                        end else begin
                            again = 1'b1;
                        end
                    end
                    ST_OCT1, ST_OCT2: begin
                        if (c inside {[8'h30:8'h37]}) begin
                            n_value = {r_value[4:0], 3'b000} + d;
                            if (r_state == ST_OCT2) begin
                                res[push_cnt[0]] = n_value;
                                push_cnt         = push_cnt + 2'd1;
                                n_value          = 8'h00;
                                n_state          = ST_PLAIN;
                            end else begin
                                n_state = ST_OCT2;
                            end
                        end else begin
                            again = 1'b1;
                        end
                    end
                    ST_HEX: begin
                        if (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]}) begin
                            n_value = {r_value[3:0], hex_digit(c)};
                        end else begin
                            again = 1'b1;
                        end
                    end
                    default: begin
                        n_state = ST_PLAIN;
                    end
                endcase

                // A non-digit closes the number, then the byte is taken as plain text.
                if (again) begin
                    res[push_cnt[0]] = r_value;
                    push_cnt         = push_cnt + 2'd1;
                    n_value          = 8'h00;
                    n_state          = ST_PLAIN;
                end
                if (r_state == ST_PLAIN || again) begin
                    if (c == CH_BACKSLASH) begin
                        n_value = 8'h00;
                        n_state = ST_ESC;
                    end else begin
                        res[push_cnt[0]] = c;
                        push_cnt         = push_cnt + 2'd1;
                    end
                end

                // Flush a pending number at the end; drop a lone backslash.
                if (i_item.string_end) begin
                    if (n_state >= ST_DEC0) begin
                        res[push_cnt[0]] = n_value;
                        push_cnt         = push_cnt + 2'd1;
                    end
                    n_state = ST_PLAIN;
                    n_value = 8'h00;
                    n_term  = 1'b0;
                end
            end
        end
    end

    assign res_item[0] = '{out_byte: res[0], run_end: (push_cnt == 2'd1)};
    assign res_item[1] = '{out_byte: res[1], run_end: 1'b1};

    // Queue: advance on pop, append new results behind what stays.
    always_comb begin
        cnt_pop = r_cnt - {1'b0, pop};
        for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
            if (pop) begin
                sh[k] = r_q[k + 1];
            end else begin
                sh[k] = r_q[k];
            end
        end
        sh[QUEUE_DEPTH - 1] = r_q[QUEUE_DEPTH - 1];
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (2'(k) < cnt_pop) begin
                n_q[k] = sh[k];
            end else if (2'(k) == cnt_pop) begin
                n_q[k] = res_item[0];
            end else begin
                n_q[k] = res_item[1];
            end
        end
        n_cnt = cnt_pop + push_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PLAIN;
            r_value <= 8'h00;
            r_term  <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_value <= n_value;
            r_term  <= n_term;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd3)
        else $error("result queue overflow");

    a_term_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_term |=> r_cnt <= $past(r_cnt))
        else $error("item after string terminator produced a result");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_item.string_end |=> r_state == ST_PLAIN && !r_term && r_value == 8'h00)
        else $error("scanner not cleared after last item of string");

    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_cnt == 2'd1 && !r_term && r_state == ST_PLAIN && !in_acc
        |-> o_result.run_end)
        else $error("lone queued result lacks end mark");
`endif

endmodule

`default_nettype wire

// ===== test/escape_sequence_decoder_unit_test.sv =====
// Testbench for the escape sequence decoder: directed table, random strings, scoreboard.
`timescale 1ns / 1ps

module escape_sequence_decoder_unit_test;
    import escd_pkg::*;

    localparam int          SOURCE_ITEMS   = 1950;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          TAIL_CYCLES    = 8;
    localparam int          IDLE_PERCENT   = 7;
    localparam int          PRINT_LIMIT    = 50;

    localparam logic [7:0]  CH_THREE   = 8'h33;
    localparam logic [7:0]  CH_FIVE    = 8'h35;
    localparam logic [7:0]  CH_SEVEN   = 8'h37;
    localparam logic [7:0]  CH_NINE    = 8'h39;
    localparam logic [7:0]  CH_UPPER_F = 8'h46;
    localparam logic [7:0]  CH_G       = 8'h67;
    localparam logic [7:0]  CH_Q       = 8'h71;
    localparam logic [7:0]  CH_Z       = 8'h7A;
    localparam logic [7:0]  CH_MAX     = 8'hFF;

    localparam logic [7:0]  NAMED_CHARS [8] = '{CH_B, CH_E, CH_F, CH_N, CH_R, CH_T, CH_V,
                                                CH_BACKSLASH};

    // One row of the directed table; count and bytes are used only where typed is set.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
        logic       typed;
        logic [1:0] count;
        logic [7:0] first;
        logic [7:0] second;
    } t_directed_row;

    localparam int NUM_DIRECTED = 27;
    localparam t_directed_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{CH_UPPER_A,   1'b0, 1'b1, 2'd1, CH_UPPER_A,   8'h00},
        '{CH_MAX,       1'b0, 1'b1, 2'd1, CH_MAX,       8'h00},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,        8'h00},
        '{CH_N,         1'b0, 1'b1, 2'd1, CODE_LF,      8'h00},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,        8'h00},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd1, CH_BACKSLASH, 8'h00},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,        8'h00},
        '{CH_E,         1'b0, 1'b1, 2'd1, CODE_ESC,     8'h00},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,        8'h00},
        '{CH_Q,         1'b0, 1'b1, 2'd1, CH_Q,         8'h00},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,        8'h00},
        '{CH_D,         1'b0, 1'b1, 2'd0, 8'h00,        8'h00},
        '{CH_SEVEN,     1'b0, 1'b0, 2'd0, 8'h00,        8'h00},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd1, 8'h07,        8'h00},
        '{CH_THREE,     1'b0, 1'b1, 2'd0, 8'h00,        8'h00},
        '{CH_SEVEN,     1'b0, 1'b0, 2'd0, 8'h00,        8'h00},
        '{CH_SEVEN,     1'b0, 1'b1, 2'd1, CH_MAX,       8'h00},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,        8'h00},
        '{CH_X,         1'b0, 1'b1, 2'd0, 8'h00,        8'h00},
        '{CH_G,         1'b0, 1'b1, 2'd2, 8'h00,        CH_G},
        '{CH_BACKSLASH, 1'b1, 1'b1, 2'd0, 8'h00,        8'h00},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,        8'h00},
        '{CH_X,         1'b0, 1'b1, 2'd0, 8'h00,        8'h00},
        '{CH_FIVE,      1'b0, 1'b0, 2'd0, 8'h00,        8'h00},
        '{CH_NUL,       1'b0, 1'b1, 2'd1, 8'h05,        8'h00},
        '{CH_Z,         1'b0, 1'b1, 2'd0, 8'h00,        8'h00},
        '{CH_Z,         1'b1, 1'b1, 2'd0, 8'h00,        8'h00}
    };

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    t_in_item   i_item  = '0;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    t_out_item  o_result;

    // Decoder copy kept by the testbench
    t_scan_state scan_q = ST_PLAIN;
    logic [7:0]  number_q = 8'h00;
    logic        ended_q = 1'b0;

    t_out_item  step_chars [$];
    t_out_item  expected_chars [$];
    t_in_item   source_text [$];
    t_out_item  head_char;
    int         mismatch_count = 0;
    int         source_count = 0;
    int         stall_cycles = 0;
    logic       quiet_run = 1'b0;

    escape_sequence_decoder_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("mismatch: %s", what);
        end
        mismatch_count++;
    endtask

    task automatic emit_char(input logic [7:0] value);
        t_out_item r;
        r.out_byte = value;
        r.run_end  = 1'b0;
        if (step_chars.size() < 2) begin
            step_chars.push_back(r);
        end
    endtask

    task automatic clear_decoder();
        scan_q   = ST_PLAIN;
        number_q = 8'h00;
        ended_q  = 1'b0;
    endtask

    // Advance the decoder copy by one byte; leave its output in step_chars.
    task automatic decode_escape(input t_in_item it);
        logic [7:0] c;
        logic [7:0] acc;
        logic [7:0] diff;
        logic       again;
        logic       is_hex;
        t_out_item  last;
        c   = it.in_byte;
        acc = number_q;
        step_chars.delete();
        if (ended_q) begin
            if (it.string_end) begin
                clear_decoder();
            end
        end else if (c == CH_NUL) begin
            if (scan_q >= ST_DEC0) begin
                emit_char(acc);
            end
            scan_q   = ST_PLAIN;
            number_q = 8'h00;
            ended_q  = !it.string_end;
        end else begin
            do begin
                again = 1'b0;
                case (scan_q)
                    ST_PLAIN: begin
                        if (c == CH_BACKSLASH) begin
                            acc    = 8'h00;
                            scan_q = ST_ESC;
                        end else begin
                            emit_char(c);
                        end
                    end
                    ST_ESC: begin
                        scan_q = ST_PLAIN;
                        case (c)
                            CH_B: emit_char(CODE_BS);
                            CH_E: emit_char(CODE_ESC);
                            CH_F: emit_char(CODE_FF);
                            CH_N: emit_char(CODE_LF);
                            CH_R: emit_char(CODE_CR);
                            CH_T: emit_char(CODE_HT);
                            CH_V: emit_char(CODE_VT);
                            CH_D: begin
                                acc    = 8'h00;
                                scan_q = ST_DEC0;
                            end
                            CH_X: begin
                                acc    = 8'h00;
                                scan_q = ST_HEX;
                            end
                            default: begin
                                if (c >= CH_ZERO && c <= CH_SEVEN) begin
                                    acc    = c - CH_ZERO;
                                    scan_q = ST_OCT1;
                                end else begin
                                    emit_char(c);
                                end
                            end
                        endcase
                    end
                    ST_DEC0, ST_DEC1, ST_DEC2: begin
                        if (c >= CH_ZERO && c <= CH_NINE) begin
                            acc = acc * 8'd10 + (c - CH_ZERO);
                            if (scan_q == ST_DEC2) begin
                                emit_char(acc);
                                acc    = 8'h00;
                                scan_q = ST_PLAIN;
                            end else begin
                                scan_q = t_scan_state'(scan_q + 3'd1);
                            end
                        end else begin
                            again = 1'b1;
                        end
                    end
                    ST_OCT1, ST_OCT2: begin
                        if (c >= CH_ZERO && c <= CH_SEVEN) begin
                            diff = c - CH_ZERO;
                            acc  = {acc[4:0], diff[2:0]};
                            if (scan_q == ST_OCT2) begin
                                emit_char(acc);
                                acc    = 8'h00;
                                scan_q = ST_PLAIN;
                            end else begin
                                scan_q = ST_OCT2;
                            end
                        end else begin
                            again = 1'b1;
                        end
                    end
                    default: begin
                        is_hex = 1'b1;
                        diff   = 8'h00;
                        if (c >= CH_ZERO && c <= CH_NINE) begin
                            diff = c - CH_ZERO;
                        end else if (c >= CH_LOWER_A && c <= CH_F) begin
                            diff = c - CH_LOWER_A + 8'd10;
                        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
                            diff = c - CH_UPPER_A + 8'd10;
                        end else begin
                            is_hex = 1'b0;
                        end
                        if (is_hex) begin
                            acc = {acc[3:0], diff[3:0]};
                        end else begin
                            again = 1'b1;
                        end
                    end
                endcase
                // A non-digit ends the number; the byte is then taken as plain text
                if (again) begin
                    emit_char(acc);
                    acc    = 8'h00;
                    scan_q = ST_PLAIN;
                end
            end while (again);
            number_q = acc;
            if (it.string_end) begin
                if (scan_q >= ST_DEC0) begin
                    emit_char(acc);
                end
                clear_decoder();
            end
        end
        if (step_chars.size() > 0) begin
            last = step_chars.pop_back();
            last.run_end = 1'b1;
            step_chars.push_back(last);
        end
    endtask

    // Hold the item on the bus until it is taken, idling now and then beforehand.
    task automatic present_item(input t_in_item it);
        while (!quiet_run && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic add_char(input logic [7:0] b);
        t_in_item it;
        it.in_byte    = b;
        it.string_end = 1'b0;
        source_text.push_back(it);
    endtask

    // Mostly well-formed escapes with random content, plus some noise and stray zeros.
    task automatic build_string();
        int         tokens;
        int         kind;
        int         r;
        logic [7:0] b;
        t_in_item   tail;
        source_text.delete();
        tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
        repeat (tokens) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                do begin
                    b = 8'($urandom_range(1, 255));
                end while (b == CH_BACKSLASH);
                add_char(b);
            end else if (kind < 50) begin
                add_char(CH_BACKSLASH);
                add_char(NAMED_CHARS[$urandom_range(0, 7)]);
            end else if (kind < 62) begin
                add_char(CH_BACKSLASH);
                add_char(CH_D);
                repeat ($urandom_range(0, 4)) add_char(8'(CH_ZERO + $urandom_range(0, 9)));
            end else if (kind < 74) begin
                add_char(CH_BACKSLASH);
                repeat ($urandom_range(1, 3)) add_char(8'(CH_ZERO + $urandom_range(0, 7)));
            end else if (kind < 86) begin
                add_char(CH_BACKSLASH);
                add_char(CH_X);
                repeat ($urandom_range(0, 4)) begin
                    r = $urandom_range(0, 21);
                    if (r < 10) begin
                        add_char(8'(CH_ZERO + r));
                    end else if (r < 16) begin
                        add_char(8'(CH_LOWER_A + r - 10));
                    end else begin
                        add_char(8'(CH_UPPER_A + r - 16));
                    end
                end
            end else if (kind < 92) begin
                add_char(CH_BACKSLASH);
                add_char(8'($urandom_range(0, 255)));
            end else if (kind < 97) begin
                add_char(8'($urandom_range(0, 255)));
            end else begin
                add_char(CH_NUL);
                repeat ($urandom_range(0, 3)) add_char(8'($urandom_range(0, 255)));
            end
        end
        tail = source_text.pop_back();
        tail.string_end = 1'b1;
        source_text.push_back(tail);
    endtask

    always @(posedge i_clk) begin
        i_ready <= quiet_run || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("result %h/%b with nothing expected",
                                          o_result.out_byte, o_result.run_end));
            end else begin
                head_char = expected_chars.pop_front();
                if (o_result.out_byte !== head_char.out_byte) begin
                    report_mismatch($sformatf("out_byte %h, expected %h",
                                              o_result.out_byte, head_char.out_byte));
                end
                if (o_result.run_end !== head_char.run_end) begin
                    report_mismatch($sformatf("run_end %b, expected %b on byte %h",
                                              o_result.run_end, head_char.run_end,
                                              head_char.out_byte));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("escape_sequence_decoder_unit_test: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_directed_row row;
        t_in_item      it;
        t_out_item     typed_char;
        logic          pressure_done;
        pressure_done = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int idx = 0; idx < NUM_DIRECTED; idx++) begin
            row = DIRECTED_ROWS[idx];
            it.in_byte    = row.in_byte;
            it.string_end = row.string_end;
            present_item(it);
            decode_escape(it);
            if (row.typed) begin
                for (int k = 0; k < row.count; k++) begin
                    typed_char.out_byte = (k == 0) ? row.first : row.second;
                    typed_char.run_end  = (k == row.count - 1);
                    expected_chars.push_back(typed_char);
                end
            end else begin
                foreach (step_chars[k]) expected_chars.push_back(step_chars[k]);
            end
        end

        while (source_count < SOURCE_ITEMS) begin
            quiet_run = (source_count >= 500 && source_count < 900);
            // Hold the sender once until the output has drained completely
            if (!pressure_done && source_count >= 1200) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (expected_chars.size() != 0) begin
                    @(posedge i_clk);
                end
                pressure_done = 1'b1;
            end
            build_string();
            foreach (source_text[j]) begin
                present_item(source_text[j]);
                if (!ended_q) begin
                    source_count++;
                end
                decode_escape(source_text[j]);
                foreach (step_chars[k]) expected_chars.push_back(step_chars[k]);
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_chars.size()));
        end
        if (mismatch_count == 0) begin
            $display("escape_sequence_decoder_unit_test: done, clean");
        end else begin
            $display("escape_sequence_decoder_unit_test: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/escd_pkg.sv
rtl/escape_sequence_decoder_unit.sv
test/escape_sequence_decoder_unit_test.sv
